FILE: hw/rtl/rtm_pkg.sv
// rtm_pkg: shared types and constants of the rectangle track matcher
// used by every file of the block, no dependencies
`default_nettype none

package rtm_pkg;

  // defaults of the top level parameters
  localparam int MAX_RECTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // fixed widths of configuration and result fields
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int LIM_W       = 2 * CFG_W;
  localparam int INDEX_OUT_W = 4;
  localparam int SCORE_OUT_W = 14;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    CMD_LOAD      = 1'b0,
    CMD_FRAME_END = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic                   has_previous;
    logic [INDEX_OUT_W-1:0] prev_index;
    logic                   matched;
    logic [INDEX_OUT_W-1:0] match_index;
    logic [SCORE_OUT_W-1:0] match_score;
    logic                   load_overflow;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rtm_front.sv
// rtm_front: input stage, decodes the command and pushes it to the queue
// depends on rtm_pkg
`default_nettype none

module rtm_front #(
  parameter int COORD_BITS = rtm_pkg::COORD_BITS_DEF,
  localparam int EntryW    = 1 + 4 * COORD_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  func_i,
  input  wire logic [COORD_BITS-1:0] left_x_i,
  input  wire logic [COORD_BITS-1:0] top_y_i,
  input  wire logic [COORD_BITS-1:0] right_x_i,
  input  wire logic [COORD_BITS-1:0] bottom_y_i,
  output logic                       push_o,
  output logic [EntryW-1:0]          push_data_o,
  input  wire logic                  full_i
);

  logic              hold_v_q;
  logic [EntryW-1:0] hold_q;
  logic              accept;
  rtm_pkg::cmd_e     cmd;

  assign push_o      = hold_v_q && !full_i;
  assign in_stall_o  = hold_v_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = hold_q;

  // any nonzero func ends the frame
  assign cmd = func_i ? rtm_pkg::CMD_FRAME_END : rtm_pkg::CMD_LOAD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
    end else if (accept) begin
      hold_v_q <= 1'b1;
    end else if (push_o) begin
      hold_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= {cmd, left_x_i, top_y_i, right_x_i, bottom_y_i};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rtm_queue.sv
// rtm_queue: short fifo of decoded commands between front and back
// depends on rtm_pkg for its default width and depth
`default_nettype none

module rtm_queue #(
  parameter int W     = 1 + 4 * rtm_pkg::COORD_BITS_DEF,
  parameter int DEPTH = rtm_pkg::QUEUE_DEPTH,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              avail_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0]    slot_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign avail_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && avail_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rtm_back.sv
// rtm_back: rectangle stores, pairing sequencer and result register
// depends on rtm_pkg; takes commands from rtm_queue
`default_nettype none

module rtm_back #(
  parameter int MAX_RECTS  = rtm_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = rtm_pkg::COORD_BITS_DEF,
  localparam int EntryW    = 1 + 4 * COORD_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      avail_i,
  input  wire logic [EntryW-1:0]         cmd_data_i,
  output logic                           pop_o,
  input  wire logic [rtm_pkg::LIM_W-1:0] limit_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output rtm_pkg::result_t               out_res_o
);

  localparam int C     = COORD_BITS;
  localparam int RectW = 4 * C;
  localparam int IdxW  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int CntW  = $clog2(MAX_RECTS + 1);
  localparam int SgnW  = C + 3;
  localparam int ScW   = C + 2;
  localparam int LimW  = rtm_pkg::LIM_W;

  rtm_pkg::state_e state_q, state_d;

  // two banks, pb_q selects the one holding the previous frame
  logic [RectW-1:0] bank0_q [MAX_RECTS];
  logic [RectW-1:0] bank1_q [MAX_RECTS];
  logic [RectW-1:0] rd0_q, rd1_q;
  logic             pb_q;

  logic [CntW-1:0] prev_count_q, cur_count_q;
  logic            ovf_q;
  logic [CntW-1:0] i_q, j_q;
  logic [LimW-1:0] best_q;
  logic            found_q;
  logic [IdxW-1:0] best_j_q;

  logic            b_v_q;
  logic [IdxW-1:0] b_j_q;
  logic            c_v_q, c_hit_q;
  logic [ScW-1:0]  c_s_q;
  logic [IdxW-1:0] c_j_q;

  logic              out_valid_q;
  rtm_pkg::result_t  out_res_q, res;

  // control decode
  rtm_pkg::cmd_e   head_cmd;
  logic            is_load, is_end, cur_full, wr_en;
  logic            issue, scan_done, out_free, emit, last_res, commit;
  logic [IdxW-1:0] i_idx, j_idx, addr0, addr1, wr_idx;
  logic [RectW-1:0] wr_rect;

  // pair datapath
  logic [RectW-1:0]      prv, cur;
  logic [C-1:0]          p_x0, p_y0, p_x1, p_y1, c_x0, c_y0, c_x1, c_y1;
  logic signed [SgnW-1:0] dxs, dys, sw, sh, dx, dy;
  logic [C-1:0]          a_x0, a_y0, a_x1, a_y1;
  logic                  hit;
  logic [ScW-1:0]        score;

  assign head_cmd = rtm_pkg::cmd_e'(cmd_data_i[EntryW-1]);
  assign wr_rect  = cmd_data_i[RectW-1:0];
  assign cur_full = (cur_count_q == CntW'(MAX_RECTS));
  assign i_idx    = i_q[IdxW-1:0];
  assign j_idx    = j_q[IdxW-1:0];
  assign wr_idx   = cur_count_q[IdxW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_res = (prev_count_q == '0) || (CntW'(i_q + CntW'(1)) == prev_count_q);
  assign scan_done = (j_q == cur_count_q) && !b_v_q && !c_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtm_pkg::ST_IDLE: begin
        if (avail_i && head_cmd == rtm_pkg::CMD_FRAME_END) begin
          state_d = (prev_count_q == '0) ? rtm_pkg::ST_EMIT : rtm_pkg::ST_SCAN;
        end
      end
      rtm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = rtm_pkg::ST_EMIT;
        end
      end
      rtm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = last_res ? rtm_pkg::ST_COMMIT : rtm_pkg::ST_SCAN;
        end
      end
      rtm_pkg::ST_COMMIT: begin
        state_d = rtm_pkg::ST_IDLE;
      end
      default: state_d = rtm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o  = 1'b0;
    issue  = 1'b0;
    emit   = 1'b0;
    commit = 1'b0;
    unique case (state_q)
      rtm_pkg::ST_IDLE:   pop_o  = avail_i;
      rtm_pkg::ST_SCAN:   issue  = (j_q < cur_count_q);
      rtm_pkg::ST_EMIT:   emit   = out_free;
      rtm_pkg::ST_COMMIT: commit = 1'b1;
      default: ;
    endcase
  end

  assign is_load = pop_o && head_cmd == rtm_pkg::CMD_LOAD;
  assign is_end  = pop_o && head_cmd == rtm_pkg::CMD_FRAME_END;
  assign wr_en   = is_load && !cur_full;

  // bank holding the previous frame is read at i, the other at j
  assign addr0 = pb_q ? j_idx : i_idx;
  assign addr1 = pb_q ? i_idx : j_idx;

  always_ff @(posedge clk_i) begin
    if (wr_en && pb_q) begin
      bank0_q[wr_idx] <= wr_rect;
    end
    rd0_q <= bank0_q[addr0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !pb_q) begin
      bank1_q[wr_idx] <= wr_rect;
    end
    rd1_q <= bank1_q[addr1];
  end

  // overlap test and score of one pair
  assign prv  = pb_q ? rd1_q : rd0_q;
  assign cur  = pb_q ? rd0_q : rd1_q;
  assign p_x0 = prv[4*C-1 -: C];
  assign p_y0 = prv[3*C-1 -: C];
  assign p_x1 = prv[2*C-1 -: C];
  assign p_y1 = prv[C-1:0];
  assign c_x0 = cur[4*C-1 -: C];
  assign c_y0 = cur[3*C-1 -: C];
  assign c_x1 = cur[2*C-1 -: C];
  assign c_y1 = cur[C-1:0];

  assign dxs = $signed(SgnW'(p_x0)) + $signed(SgnW'(p_x1))
             - $signed(SgnW'(c_x0)) - $signed(SgnW'(c_x1));
  assign dys = $signed(SgnW'(p_y0)) + $signed(SgnW'(p_y1))
             - $signed(SgnW'(c_y0)) - $signed(SgnW'(c_y1));
  assign dx  = (dxs < 0) ? -dxs : dxs;
  assign dy  = (dys < 0) ? -dys : dys;
  // extents go negative when corners are swapped
  assign sw  = $signed(SgnW'(p_x1)) - $signed(SgnW'(p_x0))
             + $signed(SgnW'(c_x1)) - $signed(SgnW'(c_x0));
  assign sh  = $signed(SgnW'(p_y1)) - $signed(SgnW'(p_y0))
             + $signed(SgnW'(c_y1)) - $signed(SgnW'(c_y0));
  assign hit = (dx < sw) && (dy < sh);

  assign a_x0  = (c_x0 > p_x0) ? c_x0 - p_x0 : p_x0 - c_x0;
  assign a_y0  = (c_y0 > p_y0) ? c_y0 - p_y0 : p_y0 - c_y0;
  assign a_x1  = (c_x1 > p_x1) ? c_x1 - p_x1 : p_x1 - c_x1;
  assign a_y1  = (c_y1 > p_y1) ? c_y1 - p_y1 : p_y1 - c_y1;
  assign score = ScW'(a_x0) + ScW'(a_x1) + ScW'(a_y0) + ScW'(a_y1);

  // result of the current previous rectangle
  always_comb begin
    res               = '0;
    res.has_previous  = (prev_count_q != '0);
    res.prev_index    = rtm_pkg::INDEX_OUT_W'(i_q);
    res.matched       = found_q;
    res.match_index   = found_q ? rtm_pkg::INDEX_OUT_W'(best_j_q) : '0;
    res.match_score   = found_q ? rtm_pkg::SCORE_OUT_W'(best_q) : '0;
    res.load_overflow = ovf_q;
    res.last          = last_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rtm_pkg::ST_IDLE;
      pb_q         <= 1'b0;
      prev_count_q <= '0;
      cur_count_q  <= '0;
      ovf_q        <= 1'b0;
      b_v_q        <= 1'b0;
      c_v_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      b_v_q   <= issue;
      c_v_q   <= b_v_q;
      if (wr_en) begin
        cur_count_q <= cur_count_q + CntW'(1);
      end
      if (is_load && cur_full) begin
        ovf_q <= 1'b1;
      end
      if (commit) begin
        if (cur_count_q != '0) begin
          pb_q         <= !pb_q;
          prev_count_q <= cur_count_q;
        end
        cur_count_q <= '0;
        ovf_q       <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    b_j_q   <= j_idx;
    c_hit_q <= hit;
    c_s_q   <= score;
    c_j_q   <= b_j_q;
    if (is_end) begin
      i_q      <= '0;
      j_q      <= '0;
      best_q   <= limit_i;
      found_q  <= 1'b0;
      best_j_q <= '0;
    end else if (emit) begin
      i_q      <= i_q + CntW'(1);
      j_q      <= '0;
      best_q   <= limit_i;
      found_q  <= 1'b0;
      best_j_q <= '0;
    end else begin
      if (issue) begin
        j_q <= j_q + CntW'(1);
      end
      // strict compare keeps the lowest index among equal scores
      if (c_v_q && c_hit_q && best_q > LimW'(c_s_q)) begin
        best_q   <= LimW'(c_s_q);
        best_j_q <= c_j_q;
        found_q  <= 1'b1;
      end
    end
    if (emit) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rect_track_matcher_top.sv
// rect_track_matcher_top: frame to frame association of bounding boxes
// Input channel (in_valid_i / in_stall_o): func_i=0 loads one rectangle of the
// current frame, func_i=1 ends the frame. Loads are taken one per cycle while
// the input does not stall; loads past MAX_RECTS are dropped and flagged.
// A frame end gives one result per previous rectangle on the output channel
// (out_valid_o / out_stall_i), last_o on the final one, or a single result
// with has_previous_o=0 when no previous set exists.
// Frame end sequence: the request is taken, then for each previous rectangle
// one pair per current rectangle goes through the compare pipeline each
// cycle, the pipeline drains and the result is handed off; last the banks
// are swapped when the current frame holds rectangles.
// Loads queue behind a frame end in a 4-entry command fifo plus the front holding
// register, and the input stalls once both fill.
// Config port (cfg_valid_i / cfg_ready_o) is always ready: index 0 image
// width, index 1 image height; write it only while the block is idle.
// Reset clears counts, flags and registers to 640 x 480; rectangle stores
// hold no reset value. A stalled result holds in the output register
// while the front keeps taking loads until the fifo and its holding register fill.
`default_nettype none

module rect_track_matcher_top #(
  parameter int MAX_RECTS  = rtm_pkg::MAX_RECTS_DEF,
  parameter int COORD_BITS = rtm_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rtm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rtm_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              func_i,
  input  wire logic [COORD_BITS-1:0]             left_x_i,
  input  wire logic [COORD_BITS-1:0]             top_y_i,
  input  wire logic [COORD_BITS-1:0]             right_x_i,
  input  wire logic [COORD_BITS-1:0]             bottom_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   has_previous_o,
  output logic [rtm_pkg::INDEX_OUT_W-1:0]        prev_index_o,
  output logic                                   matched_o,
  output logic [rtm_pkg::INDEX_OUT_W-1:0]        match_index_o,
  output logic [rtm_pkg::SCORE_OUT_W-1:0]        match_score_o,
  output logic                                   load_overflow_o,
  output logic                                   last_o
);

  localparam int EntryW = 1 + 4 * COORD_BITS;

  logic [rtm_pkg::CFG_W-1:0] width_q, width_d;
  logic [rtm_pkg::CFG_W-1:0] height_q, height_d;
  logic [rtm_pkg::LIM_W-1:0] limit_q;

  logic              push, full, pop, avail;
  logic [EntryW-1:0] push_data, head_data;
  rtm_pkg::result_t  res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rtm_pkg::CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        rtm_pkg::CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rtm_pkg::WIDTH_RST;
      height_q <= rtm_pkg::HEIGHT_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // score limit, settles long before a frame end reaches the back
  always_ff @(posedge clk_i) begin
    limit_q <= rtm_pkg::LIM_W'(width_q) * rtm_pkg::LIM_W'(height_q);
  end

  rtm_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .left_x_i    (left_x_i),
    .top_y_i     (top_y_i),
    .right_x_i   (right_x_i),
    .bottom_y_i  (bottom_y_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  rtm_queue #(
    .W     (EntryW),
    .DEPTH (rtm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .data_o  (head_data)
  );

  rtm_back #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .cmd_data_i  (head_data),
    .pop_o       (pop),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (res)
  );

  assign has_previous_o  = res.has_previous;
  assign prev_index_o    = res.prev_index;
  assign matched_o       = res.matched;
  assign match_index_o   = res.match_index;
  assign match_score_o   = res.match_score;
  assign load_overflow_o = res.load_overflow;
  assign last_o          = res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/rtm_checker.sv
// rtm_checker: port level assertions of the rectangle track matcher
// depends on rtm_pkg; bound to rect_track_matcher_top below
`default_nettype none

module rtm_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic                              has_previous_o,
  input wire logic [rtm_pkg::INDEX_OUT_W-1:0]   prev_index_o,
  input wire logic                              matched_o,
  input wire logic [rtm_pkg::INDEX_OUT_W-1:0]   match_index_o,
  input wire logic [rtm_pkg::SCORE_OUT_W-1:0]   match_score_o,
  input wire logic                              last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(prev_index_o) && $stable(match_score_o)
                                   && $stable(last_o))
    else $error("result changed while stalled");

  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> match_index_o == '0 && match_score_o == '0)
    else $error("unmatched result carries match data");

  a_no_prev_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_previous_o |-> last_o && !matched_o && prev_index_o == '0)
    else $error("no-previous result is not a lone final result");

endmodule

bind rect_track_matcher_top rtm_checker u_rtm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .has_previous_o (has_previous_o),
  .prev_index_o   (prev_index_o),
  .matched_o      (matched_o),
  .match_index_o  (match_index_o),
  .match_score_o  (match_score_o),
  .last_o         (last_o)
);

`default_nettype wire

FILE: tb/sv/tb_rect_track_matcher_top.sv
// tb_rect_track_matcher_top: self-checking bench of the rectangle track matcher
// scripted frames first, then random tracked scenes over several image sizes
// depends on rtm_pkg and rect_track_matcher_top
module tb_rect_track_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRECT       = rtm_pkg::MAX_RECTS_DEF;
  localparam int CW          = rtm_pkg::COORD_BITS_DEF;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 25;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [CW-1:0] x0;
    logic [CW-1:0] y0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y1;
  } box_t;

  typedef struct {
    rtm_pkg::cmd_e    cmd;
    box_t             box;
    bit               typed;
    rtm_pkg::result_t want;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [rtm_pkg::CFG_IDX_W-1:0]   cfg_index_i = rtm_pkg::CFG_IMAGE_WIDTH;
  logic [rtm_pkg::CFG_W-1:0]       cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic                            func_i = rtm_pkg::CMD_LOAD;
  logic [CW-1:0]                   left_x_i = '0;
  logic [CW-1:0]                   top_y_i = '0;
  logic [CW-1:0]                   right_x_i = '0;
  logic [CW-1:0]                   bottom_y_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            has_previous_o;
  logic [rtm_pkg::INDEX_OUT_W-1:0] prev_index_o;
  logic                            matched_o;
  logic [rtm_pkg::INDEX_OUT_W-1:0] match_index_o;
  logic [rtm_pkg::SCORE_OUT_W-1:0] match_score_o;
  logic                            load_overflow_o;
  logic                            last_o;

  // tracker state kept by the bench
  box_t                      prev_set [NRECT];
  box_t                      cur_set [NRECT];
  int                        prev_n = 0;
  int                        cur_n = 0;
  bit                        overflow_seen = 1'b0;
  logic [rtm_pkg::CFG_W-1:0] img_w = rtm_pkg::WIDTH_RST;
  logic [rtm_pkg::CFG_W-1:0] img_h = rtm_pkg::HEIGHT_RST;

  rtm_pkg::result_t frame_reports[$];
  rtm_pkg::result_t due_reports[$];
  stim_row_t        script[$];
  bit               row_typed = 1'b0;
  rtm_pkg::result_t row_want = '0;
  bit               quiet = 1'b0;
  int               err_count = 0;
  int               cycle_count = 0;

  rect_track_matcher_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .left_x_i        (left_x_i),
    .top_y_i         (top_y_i),
    .right_x_i       (right_x_i),
    .bottom_y_i      (bottom_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .has_previous_o  (has_previous_o),
    .prev_index_o    (prev_index_o),
    .matched_o       (matched_o),
    .match_index_o   (match_index_o),
    .match_score_o   (match_score_o),
    .load_overflow_o (load_overflow_o),
    .last_o          (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [CW-1:0] rand_coord(int lo, int hi);
    int v;
    v = $urandom_range(hi, lo);
    return v[CW-1:0];
  endfunction

  // move a corner by up to spread pixels, clamped to the coordinate range
  function automatic logic [CW-1:0] nudge(logic [CW-1:0] c, int spread);
    int v;
    v = int'(c) + $urandom_range(2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > (1 << CW) - 1) v = (1 << CW) - 1;
    return v[CW-1:0];
  endfunction

  function automatic rtm_pkg::result_t no_prev_result(bit ovf);
    rtm_pkg::result_t r;
    r = '0;
    r.load_overflow = ovf;
    r.last = 1'b1;
    return r;
  endfunction

  // applies one accepted request to the tracker state, frame end results
  // land in frame_reports
  function automatic void advance_tracker(rtm_pkg::cmd_e cmd, box_t b);
    int               limit, best, best_j, dx, dy, sw, sh, s;
    bit               found;
    box_t             p, c;
    rtm_pkg::result_t r;
    frame_reports.delete();
    if (cmd == rtm_pkg::CMD_LOAD) begin
      if (cur_n < NRECT) begin
        cur_set[cur_n] = b;
        cur_n++;
      end else begin
        overflow_seen = 1'b1;
      end
      return;
    end
    limit = int'(img_w) * int'(img_h);
    if (prev_n == 0) begin
      frame_reports = {frame_reports, no_prev_result(overflow_seen)};
    end else begin
      for (int i = 0; i < prev_n; i++) begin
        p = prev_set[i];
        best = limit;
        best_j = 0;
        found = 1'b0;
        for (int j = 0; j < cur_n; j++) begin
          c = cur_set[j];
          // doubled centers against summed extents, signed on both axes
          dx = mag(int'(p.x0) + int'(p.x1) - int'(c.x0) - int'(c.x1));
          dy = mag(int'(p.y0) + int'(p.y1) - int'(c.y0) - int'(c.y1));
          sw = int'(p.x1) - int'(p.x0) + int'(c.x1) - int'(c.x0);
          sh = int'(p.y1) - int'(p.y0) + int'(c.y1) - int'(c.y0);
          if (dx < sw && dy < sh) begin
            s = mag(int'(c.x0) - int'(p.x0)) + mag(int'(c.x1) - int'(p.x1))
              + mag(int'(c.y0) - int'(p.y0)) + mag(int'(c.y1) - int'(p.y1));
            if (best > s) begin
              best = s;
              best_j = j;
              found = 1'b1;
            end
          end
        end
        r = '0;
        r.has_previous = 1'b1;
        r.prev_index = i[rtm_pkg::INDEX_OUT_W-1:0];
        r.matched = found;
        r.match_index = found ? best_j[rtm_pkg::INDEX_OUT_W-1:0] : '0;
        r.match_score = found ? best[rtm_pkg::SCORE_OUT_W-1:0] : '0;
        r.load_overflow = overflow_seen;
        r.last = (i + 1 == prev_n);
        frame_reports = {frame_reports, r};
      end
    end
    if (cur_n > 0) begin
      prev_set = cur_set;
      prev_n = cur_n;
    end
    cur_n = 0;
    overflow_seen = 1'b0;
  endfunction

  function automatic void add_row(rtm_pkg::cmd_e cmd, int x0, int y0, int x1, int y1,
                                  bit typed = 1'b0, rtm_pkg::result_t want = '0);
    stim_row_t row;
    row.cmd = cmd;
    row.box.x0 = x0[CW-1:0];
    row.box.y0 = y0[CW-1:0];
    row.box.x1 = x1[CW-1:0];
    row.box.y1 = y1[CW-1:0];
    row.typed = typed;
    row.want = want;
    script = {script, row};
  endfunction

  task automatic send_item(rtm_pkg::cmd_e cmd, box_t b, bit typed,
                           rtm_pkg::result_t want);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= cmd;
    left_x_i   <= b.x0;
    top_y_i    <= b.y0;
    right_x_i  <= b.x1;
    bottom_y_i <= b.y1;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [rtm_pkg::CFG_IDX_W-1:0] idx,
                           logic [rtm_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rtm_pkg::CFG_IMAGE_WIDTH:  img_w = val;
      rtm_pkg::CFG_IMAGE_HEIGHT: img_h = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender until every pending result is out, then let the block settle
  task automatic drain(int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 6);
  end

  always @(posedge clk_i) begin : accept_mon
    box_t b;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      b.x0 = left_x_i;
      b.y0 = top_y_i;
      b.x1 = right_x_i;
      b.y1 = bottom_y_i;
      advance_tracker(rtm_pkg::cmd_e'(func_i), b);
      if (row_typed) begin
        due_reports = {due_reports, row_want};
      end else begin
        due_reports = {due_reports, frame_reports};
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    rtm_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_reports.size() == 0) begin
        $error("result with no request pending: prev_index %0d", prev_index_o);
        err_count++;
      end else begin
        want = due_reports.pop_front();
        if (has_previous_o !== want.has_previous) begin
          $error("has_previous: expected %0d, got %0d", want.has_previous, has_previous_o);
          err_count++;
        end
        if (prev_index_o !== want.prev_index) begin
          $error("prev_index: expected %0d, got %0d", want.prev_index, prev_index_o);
          err_count++;
        end
        if (matched_o !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, matched_o);
          err_count++;
        end
        if (match_index_o !== want.match_index) begin
          $error("match_index: expected %0d, got %0d", want.match_index, match_index_o);
          err_count++;
        end
        if (match_score_o !== want.match_score) begin
          $error("match_score: expected %0d, got %0d", want.match_score, match_score_o);
          err_count++;
        end
        if (load_overflow_o !== want.load_overflow) begin
          $error("load_overflow: expected %0d, got %0d", want.load_overflow,
                 load_overflow_o);
          err_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int                        sent, nload, spread, k, w, h;
    box_t                      b, base;
    logic [rtm_pkg::CFG_W-1:0] width_set [PHASES];
    logic [rtm_pkg::CFG_W-1:0] height_set [PHASES];
    width_set  = '{13'd4096, 13'd1, 13'd0,   13'd20, 13'd8191, 13'd640, 13'd0};
    height_set = '{13'd4096, 13'd1, 13'd480, 13'd15, 13'd8191, 13'd480, 13'd0};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // frame end right after reset: nothing to pair with
    add_row(rtm_pkg::CMD_FRAME_END, 0, 0, 0, 0, 1'b1, no_prev_result(1'b0));
    // fill the store with corner cases, the seventeenth load is dropped
    add_row(rtm_pkg::CMD_LOAD, 0, 0, 4095, 4095);
    add_row(rtm_pkg::CMD_LOAD, 4095, 4095, 0, 0);
    add_row(rtm_pkg::CMD_LOAD, 0, 0, 0, 0);
    add_row(rtm_pkg::CMD_LOAD, 4095, 4095, 4095, 4095);
    add_row(rtm_pkg::CMD_LOAD, 'hAAA, 'h555, 'hFFF, 'hAAB);
    add_row(rtm_pkg::CMD_LOAD, 'h555, 'hAAA, 'h800, 'hFFF);
    add_row(rtm_pkg::CMD_LOAD, 100, 100, 200, 200);
    add_row(rtm_pkg::CMD_LOAD, 150, 150, 260, 240);
    add_row(rtm_pkg::CMD_LOAD, 10, 20, 30, 40);
    add_row(rtm_pkg::CMD_LOAD, 2048, 0, 4095, 2047);
    add_row(rtm_pkg::CMD_LOAD, 0, 2048, 2047, 4095);
    add_row(rtm_pkg::CMD_LOAD, 1000, 1000, 1001, 1001);
    add_row(rtm_pkg::CMD_LOAD, 5, 5, 4090, 4090);
    add_row(rtm_pkg::CMD_LOAD, 300, 300, 300, 400);
    add_row(rtm_pkg::CMD_LOAD, 4000, 10, 4095, 20);
    add_row(rtm_pkg::CMD_LOAD, 1, 1, 2, 2);
    add_row(rtm_pkg::CMD_LOAD, 7, 7, 9, 9);
    add_row(rtm_pkg::CMD_FRAME_END, 4095, 4095, 4095, 4095, 1'b1, no_prev_result(1'b1));
    // exact copy, a near copy and a box with mixed swapped corners
    add_row(rtm_pkg::CMD_LOAD, 100, 100, 200, 200);
    add_row(rtm_pkg::CMD_LOAD, 104, 98, 206, 203);
    add_row(rtm_pkg::CMD_LOAD, 4095, 0, 0, 4095);
    add_row(rtm_pkg::CMD_FRAME_END, 0, 0, 0, 0);
    // empty current frame keeps the previous set
    add_row(rtm_pkg::CMD_FRAME_END, 0, 0, 0, 0);

    foreach (script[r]) send_item(script[r].cmd, script[r].box, script[r].typed,
                                  script[r].want);

    for (int p = 0; p < PHASES; p++) begin
      drain(20);
      w = width_set[p];
      h = height_set[p];
      if (p == PHASES - 1) begin
        w = $urandom_range(4096, 1);
        h = $urandom_range(64, 1);
      end
      write_reg(rtm_pkg::CFG_IMAGE_WIDTH, w[rtm_pkg::CFG_W-1:0]);
      write_reg(rtm_pkg::CFG_IMAGE_HEIGHT, h[rtm_pkg::CFG_W-1:0]);
      quiet = (p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        k = $urandom_range(99);
        nload = (k < 80) ? $urandom_range(5) :
                (k < 95) ? $urandom_range(15, 6) : $urandom_range(19, 17);
        repeat (nload) begin
          k = $urandom_range(99);
          if (k < 60 && prev_n > 0) begin
            // tracked object drifting from the previous frame
            base = prev_set[$urandom_range(prev_n - 1)];
            spread = ($urandom_range(3) == 0) ? 0 :
                     ($urandom_range(4) == 0) ? 60 : 6;
            b.x0 = nudge(base.x0, spread);
            b.y0 = nudge(base.y0, spread);
            b.x1 = nudge(base.x1, spread);
            b.y1 = nudge(base.y1, spread);
          end else if (k < 85) begin
            b.x0 = rand_coord(0, 3800);
            b.y0 = rand_coord(0, 3800);
            b.x1 = rand_coord(int'(b.x0), int'(b.x0) + 295);
            b.y1 = rand_coord(int'(b.y0), int'(b.y0) + 295);
          end else begin
            b.x0 = rand_coord(0, 4095);
            b.y0 = rand_coord(0, 4095);
            b.x1 = rand_coord(0, 4095);
            b.y1 = rand_coord(0, 4095);
          end
          send_item(rtm_pkg::CMD_LOAD, b, 1'b0, '0);
          sent++;
        end
        b.x0 = rand_coord(0, 4095);
        b.y0 = rand_coord(0, 4095);
        b.x1 = rand_coord(0, 4095);
        b.y1 = rand_coord(0, 4095);
        send_item(rtm_pkg::CMD_FRAME_END, b, 1'b0, '0);
        sent++;
      end
    end
    quiet = 1'b0;

    drain(40);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
